// File: sv/ita_pkg.sv
// Shared types, constants and controller/datapath handshake structs for int_to_decimal_ascii.
`default_nettype none
package ita_pkg;

	localparam int NUM_DIGITS = 20;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int POS_W      = $clog2(NUM_DIGITS + 1);
	localparam int ITER_W     = 5;
	localparam int BITS_PER_STEP = 4;

	localparam logic [2:0] WSEL_8  = 3'd0;
	localparam logic [2:0] WSEL_16 = 3'd1;
	localparam logic [2:0] WSEL_32 = 3'd2;
	localparam logic [2:0] WSEL_64 = 3'd3;

	localparam logic [5:0] CHAR_MINUS = 6'd45;
	localparam logic [1:0] CHAR_DIGIT_HI = 2'b11;

	typedef struct packed {
		logic [63:0] raw_value;
		logic [2:0]  width_select;
		logic        is_signed;
	} ita_item_t;

	typedef struct packed {
		logic [5:0] character;
		logic       last;
	} ita_text_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} ita_state_t;

	typedef struct packed {
		logic load;
		logic convert;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} ita_cmd_t;

	typedef struct packed {
		logic iter_last;
		logic neg;
		logic top_zero;
		logic pos_one;
		logic out_free;
	} ita_status_t;

endpackage
`default_nettype wire

// File: sv/ita_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
`default_nettype none
interface ita_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/ita_ctrl.sv
// Controller state machine: sequences load, BCD conversion, sign, zero skip and digit output.
`default_nettype none
module ita_ctrl
	import ita_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  ita_status_t st,
	output ita_cmd_t    cmd
);

	ita_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.convert = 1'b1;
				if (st.iter_last) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (!st.neg) begin
					state_d = ST_SKIP;
				end else if (st.out_free) begin
					cmd.emit_sign = 1'b1;
					state_d       = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, always keep one digit
				if (st.top_zero && !st.pos_one) begin
					cmd.skip = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit_digit = 1'b1;
					if (st.pos_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: sv/ita_dp.sv
// Datapath: width cut, magnitude, 4-bit-per-cycle double dabble, digit shifter, output register.
`default_nettype none
module ita_dp
	import ita_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ita_item_t   item_data,
	input  ita_cmd_t    cmd,
	output ita_status_t st,
	output logic        text_valid,
	input  logic        text_ready,
	output ita_text_t   text_data
);

	logic [63:0]       bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [ITER_W-1:0] iter_q;
	logic [POS_W-1:0]  pos_q;
	logic              neg_q;
	logic              out_valid_q;
	logic [5:0]        char_q;
	logic              last_q;

	logic [63:0]       mask;
	logic              top_bit;
	logic [ITER_W-1:0] iters;
	logic [63:0]       mag_cut;
	logic [63:0]       mag;
	logic              neg_ld;
	logic [63:0]       aligned;
	logic [BCD_W-1:0]  bcd_next;
	logic [63:0]       bin_next;
	logic              out_free;

	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b, input logic bit_in);
		logic [BCD_W-1:0] a;
		a = b;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (a[4*i +: 4] >= 4'd5) begin
				a[4*i +: 4] = a[4*i +: 4] + 4'd3;
			end
		end
		return {a[BCD_W-2:0], bit_in};
	endfunction

	// cut to width, take magnitude modulo 2^width, left-align for the shifter
	always_comb begin
		unique case (item_data.width_select)
			WSEL_8: begin
				mask = 64'h0000_0000_0000_00FF; top_bit = item_data.raw_value[7];
				iters = ITER_W'(8 / BITS_PER_STEP);
			end
			WSEL_16: begin
				mask = 64'h0000_0000_0000_FFFF; top_bit = item_data.raw_value[15];
				iters = ITER_W'(16 / BITS_PER_STEP);
			end
			WSEL_32: begin
				mask = 64'h0000_0000_FFFF_FFFF; top_bit = item_data.raw_value[31];
				iters = ITER_W'(32 / BITS_PER_STEP);
			end
			WSEL_64: begin
				mask = 64'hFFFF_FFFF_FFFF_FFFF; top_bit = item_data.raw_value[63];
				iters = ITER_W'(64 / BITS_PER_STEP);
			end
			default: begin
				mask = '0; top_bit = 1'b0;
				iters = ITER_W'(8 / BITS_PER_STEP);
			end
		endcase
		mag_cut = item_data.raw_value & mask;
		neg_ld  = item_data.is_signed & top_bit;
		mag     = neg_ld ? ((~mag_cut + 64'd1) & mask) : mag_cut;
		unique case (item_data.width_select)
			WSEL_16: aligned = {mag[15:0], 48'd0};
			WSEL_32: aligned = {mag[31:0], 32'd0};
			WSEL_64: aligned = mag;
			default: aligned = {mag[7:0], 56'd0};
		endcase
	end

	always_comb begin
		bcd_next = bcd_q;
		bin_next = bin_q;
		for (int j = 0; j < BITS_PER_STEP; j++) begin
			bcd_next = dd_step(bcd_next, bin_next[63]);
			bin_next = {bin_next[62:0], 1'b0};
		end
	end

	assign out_free = !out_valid_q || text_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q      <= '0;
			pos_q       <= '0;
			neg_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				iter_q <= iters;
				pos_q  <= POS_W'(NUM_DIGITS);
				neg_q  <= neg_ld;
			end else if (cmd.convert) begin
				iter_q <= iter_q - ITER_W'(1);
			end else if (cmd.skip || cmd.emit_digit) begin
				pos_q <= pos_q - POS_W'(1);
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				out_valid_q <= 1'b1;
			end else if (text_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= aligned;
			bcd_q <= '0;
		end else if (cmd.convert) begin
			bin_q <= bin_next;
			bcd_q <= bcd_next;
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
		if (cmd.emit_sign) begin
			char_q <= CHAR_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= {CHAR_DIGIT_HI, bcd_q[BCD_W-1 -: 4]};
			last_q <= (pos_q == POS_W'(1));
		end
	end

	assign st.iter_last = (iter_q == ITER_W'(1));
	assign st.neg       = neg_q;
	assign st.top_zero  = (bcd_q[BCD_W-1 -: 4] == 4'd0);
	assign st.pos_one   = (pos_q == POS_W'(1));
	assign st.out_free  = out_free;

	assign text_valid          = out_valid_q;
	assign text_data.character = char_q;
	assign text_data.last      = last_q;

`ifndef SYNTHESIS
	a_emit_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_q || text_ready))
		else $error("character issued while output register is occupied");
	a_digit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_digit |-> (bcd_q[BCD_W-1 -: 4] <= 4'd9))
		else $error("BCD digit out of range at output");
	a_skip_keeps_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.skip |-> (pos_q > POS_W'(1)))
		else $error("zero skip would drop the final digit");
	a_last_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_digit && pos_q != POS_W'(1)) |=> !last_q)
		else $error("last flag set before final digit");
`endif

endmodule
`default_nettype wire

// File: sv/int_to_decimal_ascii.sv
// Top level: integer to decimal ASCII text, one character per output transfer.
// Each input transfer carries a 64-bit raw value, a width select (8/16/32/64 bits, any other
// code prints "0") and a signed flag. The text comes out most significant character first,
// with a leading '-' for negative values and last set on the final digit. An item is taken
// only while the block is idle. Conversion uses a double-dabble shifter that consumes 4 bits
// per cycle until all width bits are in; then comes the sign slot, then the zero skip, which
// drops leading zeros of the 20 BCD digits but keeps at least one, then the digit output.
// The sign and each digit wait while the output register is still occupied.
`default_nettype none
module int_to_decimal_ascii
	import ita_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ita_stream_if.sink   item,
	ita_stream_if.source text
);

	ita_cmd_t    cmd;
	ita_status_t st;
	ita_item_t   item_data;
	ita_text_t   text_data;
	logic        item_ready;
	logic        text_valid;

	assign item_data  = item.data;
	assign item.ready = item_ready;
	assign text.valid = text_valid;
	assign text.data  = text_data;

	ita_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item_ready),
		.st         (st),
		.cmd        (cmd)
	);

	ita_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_data  (item_data),
		.cmd        (cmd),
		.st         (st),
		.text_valid (text_valid),
		.text_ready (text.ready),
		.text_data  (text_data)
	);

endmodule
`default_nettype wire
